>>> rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key/value cache
// Holds the controller state type, the command bundle from the controller
// to the datapath, the fixed field widths and the operation codes.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_VALUE_BITS = 32;

  localparam int KEY_BITS  = 32;
  localparam int IN_BITS   = 32;
  localparam int DATA_BITS = 32;
  localparam int OCC_BITS  = 5;
  localparam int CAP_BITS  = 5;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } lkvc_state_t;

  typedef struct packed {
    logic load;    // capture the accepted command
    logic match;   // compare keys, pick victim, slot and winner
    logic update;  // write back ranks and entry, publish result
  } lkvc_cmd_t;

endpackage

>>> rtl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl: sequencer of the LRU key/value cache
// Steps each accepted command through the match and update phases and
// raises the result strobe after the update.
// ----------------------------------------------------------------------------
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output lkvc_cmd_t cmd,
  output logic      out_valid
);

  lkvc_state_t state_r, state_nxt;
  logic        out_valid_r;
  logic        accept;

  // A new command may enter during the update phase: state is written back
  // at the same edge that captures the next command.
  assign busy   = (state_r == ST_MATCH);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_UPDATE);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.load   = accept;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = accept ? ST_MATCH : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/lkvc_dp.sv
// ----------------------------------------------------------------------------
// lkvc_dp: entry storage and datapath of the LRU key/value cache
// Holds keys, values, recency ranks and valid bits; compares all keys in
// parallel in the match phase and rewrites ranks in the update phase.
// ----------------------------------------------------------------------------
module lkvc_dp
  import lkvc_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lkvc_cmd_t             cmd,
  input  logic                  cfg_we,
  input  logic [CAP_BITS-1:0]   cfg_wdata,
  input  logic                  in_operation,
  input  logic signed [KEY_BITS-1:0] in_key,
  input  logic [IN_BITS-1:0]    in_value,
  output logic                  out_hit,
  output logic [DATA_BITS-1:0]  out_data,
  output logic                  out_evicted,
  output logic [OCC_BITS-1:0]   out_occupancy
);

  localparam int RW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > CAP_BITS) ? CW : CAP_BITS;

  // configuration and captured command
  logic [CAP_BITS-1:0]   cap_r;
  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  // entry storage
  logic [KEY_BITS-1:0]   key_mem_r [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem_r [ENTRIES];
  logic [RW-1:0]         rank_r    [ENTRIES];
  logic [ENTRIES-1:0]    valid_r;
  logic [CW-1:0]         cnt_r;

  // match phase results
  logic [ENTRIES-1:0]    winner_r;
  logic [ENTRIES-1:0]    victim_r;
  logic                  hit_r;
  logic                  evict_r;
  logic                  slot_ok_r;
  logic [RW-1:0]         slot_r;
  logic [RW-1:0]         best_r;
  logic [VALUE_BITS-1:0] data_r;

  // result registers
  logic                  res_hit_r;
  logic [DATA_BITS-1:0]  res_data_r;
  logic                  res_evicted_r;
  logic [OCC_BITS-1:0]   res_occ_r;

  // match phase logic
  logic [LW-1:0]         cap_ext;
  logic [LW-1:0]         cap_eff;
  logic                  do_evict;
  logic [CW-1:0]         cnt_m1;
  logic [ENTRIES-1:0]    match_v;
  logic [ENTRIES-1:0]    winner_v;
  logic [ENTRIES-1:0]    victim_v;
  logic [ENTRIES-1:0]    free_v;
  logic [RW-1:0]         slot_idx;
  logic [RW-1:0]         win_rank;
  logic [VALUE_BITS-1:0] win_val;

  // update phase logic
  logic [ENTRIES-1:0]    valid_nxt;
  logic [RW-1:0]         rank_nxt [ENTRIES];
  logic [CW-1:0]         cnt_nxt;

  // Zero capacity acts as one; capacity beyond the store saturates.
  assign cap_ext  = LW'(cap_r);
  assign cap_eff  = (cap_ext == '0) ? LW'(1) :
                    (cap_ext > LW'(ENTRIES)) ? LW'(ENTRIES) : cap_ext;
  assign do_evict = (LW'(cnt_r) >= cap_eff) && (cnt_r != '0);
  assign cnt_m1   = cnt_r - CW'(1);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_v[i]  = valid_r[i] && (key_mem_r[i] == key_r);
      victim_v[i] = do_evict && valid_r[i] && (CW'(rank_r[i]) == cnt_m1);
    end
    // Most recent match wins: no other match holds a lower rank.
    for (int i = 0; i < ENTRIES; i++) begin
      winner_v[i] = match_v[i];
      for (int j = 0; j < ENTRIES; j++) begin
        if (match_v[j] && (rank_r[j] < rank_r[i])) winner_v[i] = 1'b0;
      end
    end
    free_v   = ~valid_r | victim_v;
    slot_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_v[i]) slot_idx = RW'(i);
    end
    win_rank = '0;
    win_val  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (winner_v[i]) begin
        win_rank = win_rank | rank_r[i];
        win_val  = win_val | val_mem_r[i];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    cnt_nxt   = cnt_r;
    if (op_r == OP_INSERT) begin
      valid_nxt = valid_r & ~victim_r;
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_nxt[i]) rank_nxt[i] = RW'(rank_r[i] + 1'b1);
      end
      if (slot_ok_r) begin
        valid_nxt[slot_r] = 1'b1;
        rank_nxt[slot_r]  = '0;
      end
      cnt_nxt = cnt_r - CW'(evict_r) + CW'(slot_ok_r);
    end else if (hit_r) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i] && (rank_r[i] < best_r)) rank_nxt[i] = RW'(rank_r[i] + 1'b1);
        if (winner_r[i]) rank_nxt[i] = '0;
      end
    end
  end

  // control-side state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      valid_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.update) begin
        valid_r <= valid_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      key_r <= in_key;
      val_r <= VALUE_BITS'(in_value);
    end
    if (cmd.match) begin
      winner_r  <= winner_v;
      victim_r  <= victim_v;
      hit_r     <= |winner_v;
      evict_r   <= |victim_v;
      slot_ok_r <= |free_v;
      slot_r    <= slot_idx;
      best_r    <= win_rank;
      data_r    <= win_val;
    end
    if (cmd.update) begin
      rank_r <= rank_nxt;
      if ((op_r == OP_INSERT) && slot_ok_r) begin
        key_mem_r[slot_r] <= key_r;
        val_mem_r[slot_r] <= val_r;
      end
      res_hit_r     <= (op_r == OP_LOOKUP) && hit_r;
      res_data_r    <= ((op_r == OP_LOOKUP) && hit_r) ? DATA_BITS'(data_r) : '0;
      res_evicted_r <= (op_r == OP_INSERT) && evict_r;
      res_occ_r     <= OCC_BITS'(cnt_nxt);
    end
  end

  assign out_hit       = res_hit_r;
  assign out_data      = res_data_r;
  assign out_evicted   = res_evicted_r;
  assign out_occupancy = res_occ_r;

endmodule

>>> rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fixed-capacity key/value cache, LRU replacement
// Inserts place a new entry as most recent, evicting the least recent one
// at capacity; lookups return the most recent matching entry and promote it.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_operation (0 insert, 1 lookup), in_key and
//   in_value with start; a transfer happens at a clock edge where start is
//   high and busy is low.
//   Result channel: out_valid pulses for one cycle with out_hit, out_data,
//   out_evicted and out_occupancy. Every command yields exactly one result.
//   The receiver cannot stall: take the result in the cycle it is shown.
//   Configuration: pulse cfg_we with cfg_wdata to set the capacity (zero
//   acts as one, values above ENTRIES saturate). Write only while idle.
// Timing:
//   Phase one compares all keys in parallel and picks the victim, free slot
//   and winning entry; phase two rewrites the recency ranks and the entry.
//   The result strobe is registered at the end of phase two. busy is
//   high only in the compare phase, so a new command can transfer while
//   the previous one is in its write-back phase.
// Reset (rst_n low, synchronous): all entries invalid, occupancy zero,
//   capacity 16, sequencer idle. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  logic signed [KEY_BITS-1:0] in_key,
  input  logic [IN_BITS-1:0]         in_value,
  // result channel
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [DATA_BITS-1:0]       out_data,
  output logic                       out_evicted,
  output logic [OCC_BITS-1:0]        out_occupancy,
  // configuration
  input  logic                       cfg_we,
  input  logic [CAP_BITS-1:0]        cfg_wdata
);

  lkvc_cmd_t cmd;

  // Sequencer: owns the handshake and the phase of the command in flight.
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // Datapath: entry store, key compare, rank update and result registers.
  lkvc_dp #(
    .ENTRIES    (ENTRIES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_operation  (in_operation),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_hit       (out_hit),
    .out_data      (out_data),
    .out_evicted   (out_evicted),
    .out_occupancy (out_occupancy)
  );

endmodule
